// ----- hdl/smd_pkg.sv -----
// Package for the SHA-1 message digest block.
// Holds initial chaining values, round constants and the working-variable type.
// No dependencies.
`default_nettype none

package smd_pkg;

    // Initial chaining values h0..h4
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    // Round constants, one per group of twenty rounds
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Round index boundaries (7-bit round counter)
    localparam logic [6:0] ROUND_GRP1 = 7'd20;
    localparam logic [6:0] ROUND_GRP2 = 7'd40;
    localparam logic [6:0] ROUND_GRP3 = 7'd60;
    localparam logic [6:0] ROUND_LAST = 7'd79;

    // Working variables a..e, also used for the chaining words
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } work_vars_t;

endpackage

`default_nettype wire

// ----- hdl/smd_round.sv -----
// One SHA-1 round plus the next message-schedule word.
// Combinational; shared by all 80 rounds under the top-level sequencer.
// Depends on smd_pkg.
`default_nettype none

module smd_round (
    input  smd_pkg::work_vars_t vars_i,
    input  logic [6:0]          round_i,
    input  logic [31:0]         w0_i,
    input  logic [31:0]         w2_i,
    input  logic [31:0]         w8_i,
    input  logic [31:0]         w13_i,
    output smd_pkg::work_vars_t vars_o,
    output logic [31:0]         w_new_o
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] temp;
    logic [31:0] mix;

    always_comb begin
        if (round_i < smd_pkg::ROUND_GRP1) begin
            f = (vars_i.b & vars_i.c) | (~vars_i.b & vars_i.d);
            k = smd_pkg::K0;
        end else if (round_i < smd_pkg::ROUND_GRP2) begin
            f = vars_i.b ^ vars_i.c ^ vars_i.d;
            k = smd_pkg::K1;
        end else if (round_i < smd_pkg::ROUND_GRP3) begin
            f = (vars_i.b & vars_i.c) | (vars_i.b & vars_i.d) | (vars_i.c & vars_i.d);
            k = smd_pkg::K2;
        end else begin
            f = vars_i.b ^ vars_i.c ^ vars_i.d;
            k = smd_pkg::K3;
        end
    end

    assign temp = {vars_i.a[26:0], vars_i.a[31:27]} + f + vars_i.e + k + w0_i;

    always_comb begin
        vars_o.a = temp;
        vars_o.b = vars_i.a;
        vars_o.c = {vars_i.b[1:0], vars_i.b[31:2]};
        vars_o.d = vars_i.c;
        vars_o.e = vars_i.d;
    end

    // W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t])
    assign mix     = w13_i ^ w8_i ^ w2_i ^ w0_i;
    assign w_new_o = {mix[30:0], mix[31]};

endmodule

`default_nettype wire

// ----- hdl/sha1_message_digest.sv -----
// SHA-1 message digest, streaming one byte per input item.
// Top level: byte packing, padding sequencer, round control, digest output.
// Depends on smd_pkg and smd_round.
//
// Message bytes enter on the s_ channel, one per item. s_tuser marks the
// byte as present (0 lets an item carry no byte, e.g. an empty message) and
// s_tlast marks the final item. Bytes are packed big-endian into a 16-word
// window; a byte that neither finishes a block nor ends the message is taken
// and leaves s_tready high for the next item. The 64th byte of a block
// starts the compression: 80 rounds through the single shared round unit,
// one per cycle, then the chaining add, with s_tready low throughout.
// After the final item the padding (0x80, zero fill, 64-bit bit length) is
// pushed through the same byte path at one byte per cycle, pausing while a
// block that it fills is compressed, so it spans one or two compressions.
// The digest is then held in an output register (m_tvalid high until
// taken) and the hasher is back at its initial state; new message bytes may
// be accepted while the digest waits. m_tdata carries digest words 0..4 from
// the low bits up, word 0 being the most significant word of the hash.
`default_nettype none

module sha1_message_digest (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input items
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
    input  wire logic         s_tuser,   // [0] byte_present
    input  wire logic         s_tlast,   // end_of_message
    // result items
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [159:0]      m_tdata    // [31:0] digest_word0, [63:32] digest_word1,
                                         // [95:64] digest_word2, [127:96] digest_word3,
                                         // [159:128] digest_word4
);

    localparam logic [5:0] FILL_LAST  = 6'd63;  // last byte slot of a block
    localparam logic [5:0] LEN_START  = 6'd56;  // first byte slot of length field
    localparam logic [7:0] PAD_MARKER = 8'h80;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD
    } state_t;

    state_t              state_reg, state_next;
    smd_pkg::work_vars_t chain_reg, chain_next;
    smd_pkg::work_vars_t vars_reg, vars_next;
    smd_pkg::work_vars_t vars_round;
    logic [31:0]         window_reg [16];
    logic [31:0]         window_next [16];
    logic [31:0]         acc_reg, acc_next;
    logic [63:0]         bit_length_reg, bit_length_next;
    logic [5:0]          fill_reg, fill_next;
    logic [6:0]          round_reg, round_next;
    logic                pad_active_reg, pad_active_next;   // message end seen
    logic                marker_reg, marker_next;           // 0x80 placed
    logic                len_phase_reg, len_phase_next;     // length bytes going in
    logic                final_reg, final_next;             // last compression
    logic                out_valid_reg, out_valid_next;
    logic [159:0]        out_data_reg, out_data_next;

    logic                put_en;
    logic [7:0]          put_byte;
    logic [31:0]         byte_word;
    logic [31:0]         acc_word;
    logic [31:0]         w_new;

    smd_round u_round (
        .vars_i  (vars_reg),
        .round_i (round_reg),
        .w0_i    (window_reg[0]),
        .w2_i    (window_reg[2]),
        .w8_i    (window_reg[8]),
        .w13_i   (window_reg[13]),
        .vars_o  (vars_round),
        .w_new_o (w_new)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // byte lane placement, big-endian within each word
    assign byte_word = 32'({put_byte, 24'h000000} >> {fill_reg[1:0], 3'b000});
    assign acc_word  = (fill_reg[1:0] == 2'd0) ? byte_word : (acc_reg | byte_word);

    always_comb begin
        state_next      = state_reg;
        chain_next      = chain_reg;
        vars_next       = vars_reg;
        window_next     = window_reg;
        acc_next        = acc_reg;
        bit_length_next = bit_length_reg;
        fill_next       = fill_reg;
        round_next      = round_reg;
        pad_active_next = pad_active_reg;
        marker_next     = marker_reg;
        len_phase_next  = len_phase_reg;
        final_next      = final_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        put_en          = 1'b0;
        put_byte        = 8'h00;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    put_en   = s_tuser;
                    put_byte = s_tdata;
                    if (s_tuser) begin
                        bit_length_next = bit_length_reg + 64'd8;
                    end
                    if (s_tuser && fill_reg == FILL_LAST) begin
                        state_next      = S_ROUND;
                        pad_active_next = s_tlast;
                    end else if (s_tlast) begin
                        state_next      = S_PAD;
                        pad_active_next = 1'b1;
                    end
                end
            end
            S_PAD: begin
                put_en = 1'b1;
                if (!marker_reg) begin
                    put_byte    = PAD_MARKER;
                    marker_next = 1'b1;
                end else if (len_phase_reg || fill_reg == LEN_START) begin
                    // slot 56 takes bits 63:56, slot 63 bits 7:0
                    put_byte       = bit_length_reg[{~fill_reg[2:0], 3'b000} +: 8];
                    len_phase_next = 1'b1;
                    if (fill_reg == FILL_LAST) begin
                        final_next = 1'b1;
                    end
                end
                if (fill_reg == FILL_LAST) begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND: begin
                vars_next = vars_round;
                for (int i = 0; i < 15; i++) begin
                    window_next[i] = window_reg[i+1];
                end
                window_next[15] = w_new;
                round_next      = round_reg + 7'd1;
                if (round_reg == smd_pkg::ROUND_LAST) begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                if (!final_reg) begin
                    chain_next.a = chain_reg.a + vars_reg.a;
                    chain_next.b = chain_reg.b + vars_reg.b;
                    chain_next.c = chain_reg.c + vars_reg.c;
                    chain_next.d = chain_reg.d + vars_reg.d;
                    chain_next.e = chain_reg.e + vars_reg.e;
                    state_next   = pad_active_reg ? S_PAD : S_IDLE;
                end else if (!out_valid_reg || m_tready) begin
                    // digest goes out, hasher returns to its initial state
                    out_data_next[31:0]    = chain_reg.a + vars_reg.a;
                    out_data_next[63:32]   = chain_reg.b + vars_reg.b;
                    out_data_next[95:64]   = chain_reg.c + vars_reg.c;
                    out_data_next[127:96]  = chain_reg.d + vars_reg.d;
                    out_data_next[159:128] = chain_reg.e + vars_reg.e;
                    out_valid_next  = 1'b1;
                    chain_next      = '{smd_pkg::IV0, smd_pkg::IV1, smd_pkg::IV2,
                                        smd_pkg::IV3, smd_pkg::IV4};
                    bit_length_next = 64'd0;
                    pad_active_next = 1'b0;
                    marker_next     = 1'b0;
                    len_phase_next  = 1'b0;
                    final_next      = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // shared byte path: message bytes and padding bytes alike
        if (put_en) begin
            acc_next  = acc_word;
            fill_next = fill_reg + 6'd1;
            if (fill_reg[1:0] == 2'd3) begin
                for (int i = 0; i < 15; i++) begin
                    window_next[i] = window_reg[i+1];
                end
                window_next[15] = acc_word;
            end
            if (fill_reg == FILL_LAST) begin
                vars_next  = chain_reg;
                round_next = 7'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            chain_reg      <= '{smd_pkg::IV0, smd_pkg::IV1, smd_pkg::IV2,
                                smd_pkg::IV3, smd_pkg::IV4};
            bit_length_reg <= 64'd0;
            fill_reg       <= 6'd0;
            round_reg      <= 7'd0;
            pad_active_reg <= 1'b0;
            marker_reg     <= 1'b0;
            len_phase_reg  <= 1'b0;
            final_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            chain_reg      <= chain_next;
            bit_length_reg <= bit_length_next;
            fill_reg       <= fill_next;
            round_reg      <= round_next;
            pad_active_reg <= pad_active_next;
            marker_reg     <= marker_next;
            len_phase_reg  <= len_phase_next;
            final_reg      <= final_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        vars_reg     <= vars_next;
        window_reg   <= window_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    // the block is always empty while rounds run
    a_fill_zero_in_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROUND) |-> (fill_reg == 6'd0))
        else $error("block fill not zero during rounds");

    // round 79 is followed by the chaining add
    a_round_to_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROUND && round_reg == smd_pkg::ROUND_LAST) |=> (state_reg == S_ADD))
        else $error("rounds did not end in chaining add");

    // length bytes only ever follow the marker, past slot 56; the fill
    // wraps to zero once the last length byte is in
    a_len_after_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        len_phase_reg |-> (marker_reg && pad_active_reg &&
                           (final_reg ||
                            (fill_reg[5:3] == 3'd7 && fill_reg != LEN_START))))
        else $error("length field out of place");

    // last compression only during padding
    a_final_in_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        final_reg |-> (pad_active_reg && (state_reg == S_ROUND || state_reg == S_ADD)))
        else $error("final flag outside final compression");

endmodule

`default_nettype wire

// ----- tb/sha1_digest_checker.sv -----
// Checker for sha1_message_digest: watches both stream channels, predicts digests.
// Holds its own SHA-1 model; needs only the signals of the block's ports.
`timescale 1ns / 1ps

module sha1_digest_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
    input  wire logic         s_tuser,   // [0] byte_present
    input  wire logic         s_tlast,   // end_of_message
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [159:0] m_tdata,   // [31:0] word0 .. [159:128] word4
    output int                fail_count,
    output int                expected_left,
    output int                digests_checked
);

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
    localparam logic [31:0] K_CH    = 32'h5A827999;
    localparam logic [31:0] K_PAR1  = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ   = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR2  = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [5:0]  LEN_SLOT = 6'd56;

    logic [31:0]  chain_h [5];
    logic [31:0]  blk_w [16];
    logic [5:0]   fill;
    logic [63:0]  msg_bits;
    logic [159:0] expected_digests [$];

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void reset_hash();
        chain_h[0] = H0_INIT;
        chain_h[1] = H1_INIT;
        chain_h[2] = H2_INIT;
        chain_h[3] = H3_INIT;
        chain_h[4] = H4_INIT;
        fill       = '0;
        msg_bits   = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        for (int t = 0; t < 16; t++) w[t] = blk_w[t];
        for (int t = 16; t < 80; t++)
            w[t] = rotl(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_PAR1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = K_PAR2;
            end
            tmp = rotl(a, 5) + f + e + k + w[t];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = tmp;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // big-endian byte lanes; a full block compresses at once
    function automatic void put_byte(input logic [7:0] v);
        logic [31:0] lane;
        int          sh;
        sh   = 24 - 8 * int'(fill[1:0]);
        lane = {24'd0, v} << sh;
        if (fill[1:0] == 2'd0) blk_w[fill[5:2]] = lane;
        else                   blk_w[fill[5:2]] |= lane;
        if (fill == 6'd63) begin
            fill = 6'd0;
            compress_block();
        end else begin
            fill = fill + 6'd1;
        end
    endfunction

    function automatic void finish_message();
        logic [63:0] len;
        len = msg_bits;
        put_byte(PAD_MARK);
        while (fill != LEN_SLOT) put_byte(8'h00);
        blk_w[14] = len[63:32];
        blk_w[15] = len[31:0];
        compress_block();
        expected_digests.push_back({chain_h[4], chain_h[3], chain_h[2],
                                    chain_h[1], chain_h[0]});
        reset_hash();
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < 50) $display("[%0t] MISMATCH: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_hash();
            expected_digests.delete();
            fail_count      = 0;
            digests_checked = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_digests.size() == 0) begin
                    report_mismatch($sformatf("digest %h with no message pending", m_tdata));
                end else begin
                    logic [159:0] want;
                    want = expected_digests.pop_front();
                    for (int j = 0; j < 5; j++)
                        if (m_tdata[32*j +: 32] !== want[32*j +: 32])
                            report_mismatch($sformatf("digest_word%0d got %08h expected %08h",
                                                      j, m_tdata[32*j +: 32],
                                                      want[32*j +: 32]));
                    digests_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser) begin
                    put_byte(s_tdata);
                    msg_bits = msg_bits + 64'd8;
                end
                if (s_tlast) finish_message();
            end
        end
        expected_left = expected_digests.size();
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the sha1_message_digest testbench: clock, reset, stimulus and verdict.
// Depends on the block and on sha1_digest_checker for prediction and comparison.
`timescale 1ns / 1ps

module testbench;

    // clock and stimulus; every input known from time zero
    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [7:0]   s_tdata  = 8'h00;   // [7:0] data_byte
    logic         s_tuser  = 1'b0;    // [0] byte_present
    logic         s_tlast  = 1'b0;    // end_of_message
    logic         m_tready = 1'b1;
    wire logic    s_tready;
    wire logic    m_tvalid;
    wire logic [159:0] m_tdata;       // [31:0] digest_word0 .. [159:128] digest_word4

    int fail_count, expected_left, digests_checked;

    // idle knobs, percent of cycles; changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_counted  = 0;   // items that carry a byte or an end mark
    int messages_sent  = 0;

    always #4 aclk = ~aclk;

    sha1_message_digest DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sha1_digest_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .expected_left   (expected_left),
        .digests_checked (digests_checked)
    );

    // Receiver: stall decided fresh each cycle, so stalls land on any
    // phase of the digest handshake.
    always @(negedge aclk) begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // One item on the s_ channel. Called at a falling edge; returns at the
    // falling edge after acceptance, so tvalid stays high across back-to-back
    // items with a single assignment per step.
    task automatic send_item(input logic [7:0] b, input logic present, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);   // junk while idle, must be ignored
            s_tuser  <= 1'($urandom);
            s_tlast  <= 1'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= present;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (present || last) items_counted++;
    endtask

    // A whole message of nbytes bytes. The end mark rides on the last byte
    // or on a separate byteless item; byteless filler items are sprinkled in.
    task automatic send_message(input int nbytes);
        int          pattern;
        logic        end_on_byte;
        logic [7:0]  b;
        pattern     = $urandom_range(9);
        end_on_byte = (nbytes > 0) && ($urandom_range(1) == 1);
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            case (pattern)
                0:       b = 8'hFF;
                1:       b = 8'h00;
                default: b = 8'($urandom);
            endcase
            send_item(b, 1'b1, end_on_byte && (i == nbytes - 1));
        end
        if (!end_on_byte) send_item(8'($urandom), 1'b0, 1'b1);
        messages_sent++;
    endtask

    initial begin
        int start_items, r, len;

        // synchronous reset
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, no idling.
        // empty message: a byteless end item, data must be ignored
        send_item(8'h5A, 1'b0, 1'b1);
        // "abc" with the end mark on the last byte
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // "abc" again, byteless item inside, end mark on its own item
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        // single all-ones byte, single zero byte, then both
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);

        // Random part in four idle phases. Lengths lean toward the padding
        // boundaries (55/56 and 63/64 bytes) and include multi-block runs.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            start_items = items_counted;
            while (items_counted - start_items < 90) begin
                r = $urandom_range(99);
                if (r < 15)      len = 0;
                else if (r < 55) len = $urandom_range(12, 1);
                else if (r < 75) len = $urandom_range(65, 54);
                else if (r < 90) len = $urandom_range(53, 13);
                else             len = $urandom_range(130, 110);
                send_message(len);
            end
        end
        s_tvalid <= 1'b0;

        // drain, then watch for stray digests
        while (expected_left != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("Covered %0d messages in %0d items: empty, short, block-boundary and",
                 messages_sent, items_counted);
        $display("multi-block runs under four idle/stall mixes; %0d digests compared.",
                 digests_checked);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #4_000_000;
        $display("Timeout with %0d digests outstanding", expected_left);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
